// File: hdl/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the bitmap allocation engine.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int unsigned MapBitsDefault  = 1024;
  localparam int unsigned WordBitsDefault = 32;

  localparam int unsigned OpW    = 4;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned LenW   = 11;
  localparam int unsigned ValW   = 11;
  localparam int unsigned StatW  = 2;
  localparam logic [LenW-1:0] BitsInUseReset = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_TEST = 4'd0, OP_SET = 4'd1, OP_CLR = 4'd2, OP_SET_RANGE = 4'd3,
    OP_CLR_RANGE = 4'd4, OP_FFC = 4'd5, OP_FFS = 4'd6, OP_FLS = 4'd7,
    OP_CLR_RUN = 4'd8, OP_SET_RUN = 4'd9, OP_CNT_SET = 4'd10,
    OP_CNT_CLR = 4'd11, OP_LONGEST = 4'd12, OP_NTH = 4'd13, OP_RANK = 4'd14,
    OP_NONE = 4'd15
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK = 2'd0, ST_NOTFOUND = 2'd1, ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_PASS1, S_PASS2, S_DONE
  } state_e;

endpackage

// File: hdl/bae_bit_unit.sv
// ----------------------------------------------------------------------------
// bae_bit_unit
// Shared per-bit step unit: applies one bit of the scan to the run and
// count registers and reports a hit.
// ----------------------------------------------------------------------------
module bae_bit_unit #(
  parameter int unsigned CntW = 11
) (
  input  bae_pkg::op_e      op_i,
  input  logic              bit_i,
  input  logic [CntW-1:0]   pos_i,
  input  logic [CntW-1:0]   cnt_i,
  input  logic [CntW-1:0]   best_i,
  input  logic [CntW-1:0]   len_i,
  input  logic [CntW-1:0]   k_i,
  output logic [CntW-1:0]   cnt_o,
  output logic [CntW-1:0]   best_o,
  output logic              hit_o,
  output logic [CntW-1:0]   hit_val_o
);

  logic [CntW-1:0] inc;
  assign inc = cnt_i + CntW'(1);

  always_comb begin
    cnt_o     = cnt_i;
    best_o    = best_i;
    hit_o     = 1'b0;
    hit_val_o = pos_i;
    unique case (op_i)
      bae_pkg::OP_FFC: hit_o = !bit_i;
      bae_pkg::OP_FFS, bae_pkg::OP_FLS: hit_o = bit_i;
      bae_pkg::OP_CLR_RUN, bae_pkg::OP_SET_RUN: begin
        // run of the wanted polarity
        if (bit_i == (op_i == bae_pkg::OP_SET_RUN)) begin
          cnt_o = inc;
          if (inc >= len_i) begin
            hit_o     = 1'b1;
            hit_val_o = pos_i + CntW'(1) - inc;
          end
        end else begin
          cnt_o = '0;
        end
      end
      bae_pkg::OP_CNT_SET, bae_pkg::OP_CNT_CLR, bae_pkg::OP_RANK: begin
        if (bit_i) cnt_o = inc;
      end
      bae_pkg::OP_LONGEST: begin
        if (bit_i) begin
          cnt_o = inc;
          if (inc > best_i) best_o = inc;
        end else begin
          cnt_o = '0;
        end
      end
      bae_pkg::OP_NTH: begin
        if (bit_i) begin
          if (cnt_i == k_i) hit_o = 1'b1;
          else cnt_o = inc;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/bitmap_allocation_engine.sv
// ----------------------------------------------------------------------------
// bitmap_allocation_engine
// Bitmap of resource bits with test/set/clear, range writes, searches,
// counts and rank queries, executed one bit at a time.
// ----------------------------------------------------------------------------
// Usage: drive opcode_i and the index/length fields with start_i high while
// busy_o is low; the item is taken at that edge and busy_o rises. One result
// (result_value_o, status_o) appears for one cycle with done_o high, after
// which busy_o falls. The receiver cannot stall; results are not held.
// Single-bit ops and rejected items end after their first step; the next
// item can be taken in the cycle after the result.
// Scans visit one bit per cycle through the shared bit-step unit; a seeded
// clear-run may take a second pass from zero.
// The map is stored in a word memory with one read port and one write port.
// A range write updates one bit per word write and rereads the word before
// the next bit; a reversed range finishes at once.
// Reset: bits_in_use returns to 1024 and a clearing pass zeroes the map,
// one word a cycle with busy_o high.
// bits_in_use_i is written whenever cfg_we_i is high, with no wait.
// ----------------------------------------------------------------------------
module bitmap_allocation_engine #(
  parameter int unsigned MAP_BITS  = bae_pkg::MapBitsDefault,
  parameter int unsigned WORD_BITS = bae_pkg::WordBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bae_pkg::LenW-1:0]   bits_in_use_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [bae_pkg::OpW-1:0]    opcode_i,
  input  logic [bae_pkg::IdxW-1:0]   first_index_i,
  input  logic [bae_pkg::IdxW-1:0]   last_index_i,
  input  logic [bae_pkg::LenW-1:0]   run_length_i,
  output logic                       done_o,
  output logic [bae_pkg::ValW-1:0]   result_value_o,
  output logic [bae_pkg::StatW-1:0]  status_o
);

  localparam int unsigned Words = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned PW    = $clog2(MAP_BITS + 1);   // holds MAP_BITS
  localparam int unsigned CW    = (PW > bae_pkg::LenW) ? PW : bae_pkg::LenW;

  // memory
  logic [WORD_BITS-1:0] mem [Words];
  logic [WORD_BITS-1:0] rd_q;
  logic                 we;
  logic [WAW-1:0]       waddr, raddr;
  logic [WORD_BITS-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // registers
  bae_pkg::state_e st_q, st_d;
  logic [bae_pkg::LenW-1:0] biu_q;
  bae_pkg::op_e    op_q;
  logic [CW-1:0]   a_q, b_q, len_q, n_q, seed_q;
  logic [CW-1:0]   pos_q, pos_d, cnt_q, cnt_d, best_q, best_d;
  logic            rd_ok_q, rd_ok_d;
  logic [WAW-1:0]  clr_q;
  logic [bae_pkg::ValW-1:0]  val_q, val_d;
  logic [bae_pkg::StatW-1:0] sts_q, sts_d;
  logic [CW-1:0]   n_eff;

  always_comb begin
    if (biu_q == '0) n_eff = CW'(1);
    else if (CW'(biu_q) > CW'(MAP_BITS)) n_eff = CW'(MAP_BITS);
    else n_eff = CW'(biu_q);
  end

  // bit unit
  logic            cur_bit, hit;
  logic [CW-1:0]   u_cnt, u_best, u_hval;
  assign cur_bit = rd_q[pos_q[BW-1:0]];

  bae_bit_unit #(.CntW(CW)) u_step (
    .op_i(op_q), .bit_i(cur_bit), .pos_i(pos_q), .cnt_i(cnt_q),
    .best_i(best_q), .len_i(len_q), .k_i(a_q),
    .cnt_o(u_cnt), .best_o(u_best), .hit_o(hit), .hit_val_o(u_hval)
  );

  logic is_write, is_fls, at_end;
  assign is_write = (op_q == bae_pkg::OP_SET) || (op_q == bae_pkg::OP_CLR) ||
                    (op_q == bae_pkg::OP_SET_RANGE) ||
                    (op_q == bae_pkg::OP_CLR_RANGE);
  assign is_fls   = (op_q == bae_pkg::OP_FLS);

  // first-step setup from the accepted item
  logic [CW-1:0] in_a, in_b, in_len, seed_in;
  logic          in_bad;
  bae_pkg::op_e  in_op;
  assign in_op  = bae_pkg::op_e'(opcode_i);
  assign in_a   = CW'(first_index_i);
  assign in_b   = CW'(last_index_i);
  assign in_len = CW'(run_length_i);
  assign seed_in = ((in_a + in_len) >= n_eff) ? n_eff : in_a;

  always_comb begin
    in_bad   = 1'b0;
    unique case (in_op)
      bae_pkg::OP_TEST, bae_pkg::OP_SET, bae_pkg::OP_CLR, bae_pkg::OP_RANK:
        in_bad = in_a >= n_eff;
      bae_pkg::OP_SET_RANGE, bae_pkg::OP_CLR_RANGE:
        in_bad = (in_a >= n_eff) || (in_b >= n_eff);
      bae_pkg::OP_CLR_RUN, bae_pkg::OP_SET_RUN:
        in_bad = (in_len == '0) || (in_len > n_eff);
      bae_pkg::OP_NTH: in_bad = in_a > n_eff;
      bae_pkg::OP_NONE: in_bad = 1'b1;
      default: ;
    endcase
  end

  // scan end for the current position; a reversed range ends at once
  always_comb begin
    unique case (op_q)
      bae_pkg::OP_TEST, bae_pkg::OP_SET, bae_pkg::OP_CLR: at_end = 1'b1;
      bae_pkg::OP_SET_RANGE, bae_pkg::OP_CLR_RANGE:
        at_end = (pos_q == b_q) || (b_q < a_q);
      bae_pkg::OP_FLS: at_end = pos_q == '0;
      bae_pkg::OP_RANK: at_end = pos_q == a_q;
      default: at_end = (pos_q + CW'(1)) >= n_q;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bae_pkg::S_CLEAR: if (clr_q == WAW'(Words - 1)) st_d = bae_pkg::S_IDLE;
      bae_pkg::S_IDLE: if (start_i) st_d = bae_pkg::S_PASS1;
      bae_pkg::S_PASS1, bae_pkg::S_PASS2: begin
        if (sts_q != bae_pkg::ST_OK || !rd_ok_q) begin
          if (sts_q != bae_pkg::ST_OK) st_d = bae_pkg::S_DONE;
        end else if (op_q == bae_pkg::OP_CLR_RUN && st_q == bae_pkg::S_PASS1) begin
          if (pos_q >= n_q) st_d = bae_pkg::S_PASS2;
          else if (hit || at_end) st_d = hit ? bae_pkg::S_DONE : bae_pkg::S_PASS2;
        end else if (op_q == bae_pkg::OP_CLR_RUN) begin
          if (hit || at_end || (cur_bit && pos_q >= seed_q)) st_d = bae_pkg::S_DONE;
        end else if (hit || at_end) begin
          st_d = bae_pkg::S_DONE;
        end
      end
      bae_pkg::S_DONE: st_d = bae_pkg::S_IDLE;
      default: st_d = bae_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    best_d  = best_q;
    rd_ok_d = 1'b0;
    val_d   = val_q;
    sts_d   = sts_q;
    we      = 1'b0;
    waddr   = pos_q[BW +: WAW];
    wdata   = rd_q;
    raddr   = pos_q[BW +: WAW];
    unique case (st_q)
      bae_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      bae_pkg::S_IDLE: begin
        cnt_d  = '0;
        best_d = '0;
        val_d  = '0;
        sts_d  = in_bad ? bae_pkg::ST_RANGE : bae_pkg::ST_OK;
        if (in_op == bae_pkg::OP_FLS) pos_d = n_eff - CW'(1);
        else if (in_op == bae_pkg::OP_CLR_RUN) pos_d = seed_in;
        else if (in_op == bae_pkg::OP_TEST || in_op == bae_pkg::OP_SET ||
                 in_op == bae_pkg::OP_CLR || in_op == bae_pkg::OP_SET_RANGE ||
                 in_op == bae_pkg::OP_CLR_RANGE) pos_d = in_a;
        else pos_d = '0;
        raddr   = pos_d[BW +: WAW];
        rd_ok_d = 1'b1;
      end
      bae_pkg::S_PASS1, bae_pkg::S_PASS2: begin
        if (sts_q == bae_pkg::ST_OK && rd_ok_q) begin
          if (op_q == bae_pkg::OP_CLR_RUN && st_q == bae_pkg::S_PASS1 &&
              pos_q >= n_q) begin
            // seed acts as the size: go straight to the pass from zero
            pos_d = '0; cnt_d = '0; rd_ok_d = 1'b1;
            raddr = '0;
          end else if (op_q == bae_pkg::OP_CLR_RUN && st_q == bae_pkg::S_PASS2 &&
                       cur_bit && pos_q >= seed_q) begin
            sts_d = bae_pkg::ST_NOTFOUND;
          end else if (is_write) begin
            // write the bit; the next bit waits for the reread
            wdata = rd_q;
            wdata[pos_q[BW-1:0]] = (op_q == bae_pkg::OP_SET) ||
                                   (op_q == bae_pkg::OP_SET_RANGE);
            we     = !(b_q < a_q && op_q != bae_pkg::OP_SET && op_q != bae_pkg::OP_CLR);
            waddr  = pos_q[BW +: WAW];
            if (!at_end) pos_d = pos_q + CW'(1);
          end else if (op_q == bae_pkg::OP_TEST) begin
            val_d = bae_pkg::ValW'(cur_bit);
          end else if (op_q == bae_pkg::OP_RANK && at_end) begin
            if (!cur_bit) sts_d = bae_pkg::ST_NOTFOUND;
            else val_d = bae_pkg::ValW'(cnt_q);
          end else begin
            cnt_d  = u_cnt;
            best_d = u_best;
            if (hit) begin
              val_d = bae_pkg::ValW'(u_hval);
            end else if (at_end) begin
              unique case (op_q)
                bae_pkg::OP_CNT_SET: val_d = bae_pkg::ValW'(u_cnt);
                bae_pkg::OP_CNT_CLR: val_d = bae_pkg::ValW'(n_q - u_cnt);
                bae_pkg::OP_LONGEST: val_d = bae_pkg::ValW'(u_best);
                bae_pkg::OP_CLR_RUN: begin
                  if (st_q == bae_pkg::S_PASS1) begin
                    pos_d = '0; cnt_d = '0; rd_ok_d = 1'b1; raddr = '0;
                  end else sts_d = bae_pkg::ST_NOTFOUND;
                end
                default: sts_d = bae_pkg::ST_NOTFOUND;
              endcase
            end else begin
              pos_d   = is_fls ? pos_q - CW'(1) : pos_q + CW'(1);
              raddr   = pos_d[BW +: WAW];
              rd_ok_d = 1'b1;
            end
          end
        end else if (sts_q == bae_pkg::ST_OK) begin
          // reread the word at the current position
          rd_ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= bae_pkg::S_CLEAR;
      biu_q   <= bae_pkg::BitsInUseReset;
      clr_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      rd_ok_q <= rd_ok_d;
      if (cfg_we_i) biu_q <= bits_in_use_i;
      if (st_q == bae_pkg::S_CLEAR) clr_q <= clr_q + WAW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    best_q <= best_d;
    val_q  <= val_d;
    sts_q  <= sts_d;
    if (st_q == bae_pkg::S_IDLE && start_i) begin
      op_q   <= in_op;
      a_q    <= in_a;
      b_q    <= in_b;
      len_q  <= in_len;
      n_q    <= n_eff;
      seed_q <= seed_in;
    end
  end

  // handshake and result outputs
  assign busy_o         = st_q != bae_pkg::S_IDLE;
  assign done_o         = st_q == bae_pkg::S_DONE;
  assign result_value_o = (sts_q == bae_pkg::ST_OK) ? val_q : '0;
  assign status_o       = sts_q;

endmodule
